### hw/rtl/assert_macros.svh
// Assertion helpers: clocked, disabled while reset is held low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

### hw/rtl/mbps_pkg.sv
package mbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int WIN_IDX_W     = $clog2(PATTERN_BYTES);
    localparam int FILL_W        = $clog2(PATTERN_BYTES + 1);
    localparam int LEN_REG_W     = 5;
    localparam int ADDR_W        = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_BASE_ADDRESS   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_region;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    typedef logic [PATTERN_BYTES-1:0][7:0] byte_vec_t;

    typedef struct packed {
        byte_vec_t                pattern;
        logic [PATTERN_BYTES-1:0] care;
        logic [FILL_W-1:0]        length;
    } match_cfg_t;

endpackage

### hw/rtl/masked_byte_pattern_scanner.sv
// Channel   Dir  Handshake          Payload
// s_item    in   s_valid / s_ready  data_byte, last_in_region
// m_item    out  m_valid / m_ready  found, match_address
// cfg       in   cfg_wr_en          cfg_index, cfg_wdata (no handshake back)
//
// One item per cycle sustained unless the result stalls; an item is held in the
// input register, then masked window compare and address add fill the result.
// Synchronous active-low reset empties both registers and rearms the scan.
// A stalled result holds the compare stage; the input register still takes one
// item, so s_ready drops only when both stages are full.
`include "assert_macros.svh"

module masked_byte_pattern_scanner (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mbps_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbps_pkg::out_item_t                 m_item,
    input  logic                                cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int PB = mbps_pkg::PATTERN_BYTES;
    localparam int FW = mbps_pkg::FILL_W;
    localparam int AW = mbps_pkg::ADDR_W;

    logic [63:0]                     pat_low_reg;
    logic [63:0]                     pat_high_reg;
    logic [PB-1:0]                   care_reg;
    logic [mbps_pkg::LEN_REG_W-1:0]  len_reg;
    logic [AW-1:0]                   base_reg;

    logic                s1_valid_reg, s1_valid_next;
    mbps_pkg::in_item_t  s1_item_reg;
    mbps_pkg::byte_vec_t window_reg;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       offset_reg, offset_next;
    logic                reported_reg, reported_next;
    logic                m_valid_reg, m_valid_next;
    mbps_pkg::out_item_t m_item_reg;

    mbps_pkg::match_cfg_t match_cfg;
    mbps_pkg::out_item_t  res_item;
    logic [FW-1:0]        eff_len;
    logic [FW-1:0]        fill_inc;
    logic [AW-1:0]        start_addr;
    logic                 hit;
    logic                 hit_ok;
    logic                 res_valid;
    logic                 out_free;
    logic                 s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '1;
            len_reg      <= mbps_pkg::LEN_REG_W'(1);
            base_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mbps_pkg::REG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                mbps_pkg::REG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                mbps_pkg::REG_CARE_MASK:      care_reg     <= cfg_wdata[PB-1:0];
                mbps_pkg::REG_PATTERN_LENGTH: len_reg <= cfg_wdata[mbps_pkg::LEN_REG_W-1:0];
                mbps_pkg::REG_BASE_ADDRESS:   base_reg     <= cfg_wdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (len_reg == '0) begin
            eff_len = FW'(1);
        end else if (len_reg > mbps_pkg::LEN_REG_W'(PB)) begin
            eff_len = FW'(PB);
        end else begin
            eff_len = FW'(len_reg);
        end
    end

    assign match_cfg.pattern = {pat_high_reg, pat_low_reg};
    assign match_cfg.care    = care_reg;
    assign match_cfg.length  = eff_len;

    mbps_window_match u_match (
        .window   (window_reg),
        .new_byte (s1_item_reg.data_byte),
        .cfg      (match_cfg),
        .hit      (hit)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || s1_adv;

    assign fill_inc   = (fill_reg == FW'(PB)) ? fill_reg : fill_reg + FW'(1);
    assign hit_ok     = !reported_reg && (fill_inc >= eff_len) && hit;
    assign res_valid  = hit_ok || (s1_item_reg.last_in_region && !reported_reg);
    assign start_addr = base_reg + offset_reg - AW'(eff_len) + AW'(1);

    always_comb begin
        res_item.found         = hit_ok;
        res_item.match_address = hit_ok ? start_addr : '0;
    end

    always_comb begin
        s1_valid_next = s_ready ? s_valid : s1_valid_reg;
        fill_next     = fill_reg;
        offset_next   = offset_reg;
        reported_next = reported_reg;
        if (s1_adv) begin
            if (s1_item_reg.last_in_region) begin
                fill_next     = '0;
                offset_next   = '0;
                reported_next = 1'b0;
            end else begin
                fill_next     = fill_inc;
                offset_next   = offset_reg + AW'(1);
                reported_next = reported_reg || hit_ok;
            end
        end
        m_valid_next = out_free ? (s1_adv && res_valid) : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fill_reg     <= '0;
            offset_reg   <= '0;
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fill_reg     <= fill_next;
            offset_reg   <= offset_next;
            reported_reg <= reported_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_item_reg <= s_item;
        end
        if (s1_adv) begin
            window_reg <= {window_reg[PB-2:0], s1_item_reg.data_byte};
        end
        if (s1_adv && res_valid) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= FW'(PB), "fill count overran window")
    `ASSERT_IMPLY(a_not_found_zero, aclk, aresetn, m_valid_reg && !m_item_reg.found,
                  m_item_reg.match_address == '0, "not-found result carries an address")
    `ASSERT_IMPLY(a_single_result, aclk, aresetn, s1_adv && reported_reg, !res_valid,
                  "second result in one region")
    `ASSERT_NEXT(a_rearm, aclk, aresetn, s1_adv && s1_item_reg.last_in_region,
                 fill_reg == '0 && offset_reg == '0 && !reported_reg, "scan did not rearm")

endmodule

### hw/rtl/mbps_window_match.sv
module mbps_window_match (
    input  mbps_pkg::byte_vec_t  window,
    input  logic [7:0]           new_byte,
    input  mbps_pkg::match_cfg_t cfg,
    output logic                 hit
);

    mbps_pkg::byte_vec_t                window_new;
    logic [mbps_pkg::PATTERN_BYTES-1:0] pos_ok;

    always_comb begin
        window_new[0] = new_byte;
        for (int j = 1; j < mbps_pkg::PATTERN_BYTES; j++) begin
            window_new[j] = window[j-1];
        end
    end

    always_comb begin
        logic [mbps_pkg::FILL_W-1:0] idx;
        for (int k = 0; k < mbps_pkg::PATTERN_BYTES; k++) begin
            idx = cfg.length - mbps_pkg::FILL_W'(k) - mbps_pkg::FILL_W'(1);
            pos_ok[k] = (mbps_pkg::FILL_W'(k) >= cfg.length) || !cfg.care[k] ||
                        (window_new[idx[mbps_pkg::WIN_IDX_W-1:0]] == cfg.pattern[k]);
        end
    end

    assign hit = &pos_ok;

endmodule
